// ----- design/trps_pkg.sv -----
// ----------------------------------------------------------------------------
// trps_pkg
// Shared types, codes and constants of the tile request priority scheduler.
// ----------------------------------------------------------------------------
package trps_pkg;

  localparam int unsigned KeyW    = 61;
  localparam int unsigned ClsW    = 3;
  localparam int unsigned LimW    = 7;
  localparam int unsigned StampW  = 32;
  localparam int unsigned DupW    = 8;
  localparam int unsigned DropW   = 32;
  localparam int unsigned OutcW   = 4;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned NumCls  = 5;
  localparam int unsigned SlotsDefault = 64;
  localparam logic [LimW-1:0] RequestLimitReset = 7'd32;
  localparam logic [LimW-1:0] DirtyLimitReset   = 7'd32;

  localparam logic [ClsW-1:0] ClsDirty  = 3'd3;
  localparam logic [ClsW-1:0] PlaceRend = 3'd5;

  localparam logic [CfgIdxW-1:0] RegRequestLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] RegDirtyLimit   = 1'd1;

  typedef enum logic [OpW-1:0] {
    OP_ADD      = 2'd0,
    OP_FETCH    = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_COUNT    = 2'd3
  } op_e;

  typedef enum logic [OutcW-1:0] {
    OC_QUEUED   = 4'd0,
    OC_DIRTY    = 4'd1,
    OC_DUP      = 4'd2,
    OC_PROMOTED = 4'd3,
    OC_MATCHBG  = 4'd4,
    OC_DROPPED  = 4'd5,
    OC_FETCHED  = 4'd6,
    OC_EMPTY    = 4'd7,
    OC_REMOVED  = 4'd8,
    OC_MISSING  = 4'd9,
    OC_COUNT    = 4'd10
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_LOOKUP,
    ST_DECIDE,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic commit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

// ----- design/trps_ctrl.sv -----
// ----------------------------------------------------------------------------
// trps_ctrl
// Sequencer: load the command, sweep the slot table, decide, then report.
// ----------------------------------------------------------------------------
module trps_ctrl import trps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    done_o  = 1'b0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_o.load     = 1'b1;
          ctrl_o.scan_clr = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        ctrl_o.scan_step = 1'b1;
        state_d          = ST_LOOKUP;
      end
      // side reads of the matched and best slots settle here
      ST_LOOKUP: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        ctrl_o.commit = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> busy) else $error("load without busy");
  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.commit |=> done_o) else $error("commit not followed by done");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("done not followed by idle");
`endif

endmodule

// ----- design/trps_dp.sv -----
// ----------------------------------------------------------------------------
// trps_dp
// Slot table, one-slot-per-cycle search and the update of counters.
// ----------------------------------------------------------------------------
module trps_dp import trps_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  input  logic                done_i,
  input  logic [OpW-1:0]      operation_i,
  input  logic [KeyW-1:0]     tile_key_i,
  input  logic [ClsW-1:0]     request_class_i,
  input  logic [LimW-1:0]     request_limit_i,
  input  logic [LimW-1:0]     bg_limit_i,
  output logic                reply_o,
  output logic [OutcW-1:0]    outcome_o,
  output logic [KeyW-1:0]     result_key_o,
  output logic [ClsW-1:0]     result_class_o,
  output logic [LimW-1:0]     class_depth_o,
  output logic [DupW-1:0]     duplicate_count_o,
  output logic [DropW-1:0]    drop_total_o
);

  localparam int unsigned IdxW = $clog2(Slots);

  // slot storage: key/stamp/origin/dupes in memories, place in memory too
  logic [KeyW-1:0]   key_mem   [Slots];
  logic [StampW-1:0] stamp_mem [Slots];
  logic [ClsW-1:0]   place_mem [Slots];
  logic [ClsW-1:0]   orig_mem  [Slots];
  logic [DupW-1:0]   dup_mem   [Slots];
  logic [Slots-1:0]  valid_q;

  logic [LimW-1:0]   cnt_q [NumCls];
  logic [StampW-1:0] stamp_ctr_q;
  logic [DropW-1:0]  drops_q;

  logic [OpW-1:0]  op_q;
  logic [KeyW-1:0] key_q;
  logic [ClsW-1:0] cls_q;

  // scan pipeline: address issued, data registered in the next cycle
  logic [IdxW-1:0]   rd_idx_q;
  logic              rd_live_q;
  logic [IdxW-1:0]   cur_idx_q;
  logic              cur_live_q;
  logic [KeyW-1:0]   rd_key_q;
  logic [StampW-1:0] rd_stamp_q;
  logic [ClsW-1:0]   rd_place_q;

  logic              match_found_q, free_found_q, best_found_q;
  logic [IdxW-1:0]   match_idx_q, free_idx_q, best_idx_q;
  logic [ClsW-1:0]   match_place_q, best_place_q;
  logic [StampW-1:0] best_age_q;

  // read port for commit
  logic [ClsW-1:0] m_orig_q, b_orig_q;
  logic [DupW-1:0] m_dup_q;
  logic [KeyW-1:0] b_key_q;

  assign stat_o.scan_last = (rd_idx_q == IdxW'(Slots - 1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= operation_i;
      key_q <= tile_key_i;
      cls_q <= request_class_i;
    end
  end

  // scan address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      rd_live_q  <= 1'b0;
      cur_live_q <= 1'b0;
      cur_idx_q  <= '0;
    end else begin
      if (ctrl_i.scan_clr) begin
        rd_idx_q  <= '0;
        rd_live_q <= 1'b1;
      end else if (ctrl_i.scan_step) begin
        if (rd_idx_q == IdxW'(Slots - 1)) begin
          rd_live_q <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
      cur_live_q <= rd_live_q && ctrl_i.scan_step;
      cur_idx_q  <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_q   <= key_mem[rd_idx_q];
    rd_stamp_q <= stamp_mem[rd_idx_q];
    rd_place_q <= place_mem[rd_idx_q];
  end

  logic              cur_valid;
  logic [StampW-1:0] cur_age;
  logic              better;
  assign cur_valid = valid_q[cur_idx_q];
  assign cur_age   = stamp_ctr_q - rd_stamp_q;
  assign better    = !best_found_q || (rd_place_q < best_place_q) ||
                     ((rd_place_q == best_place_q) && (cur_age > best_age_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
    end else if (ctrl_i.scan_clr) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
    end else if (cur_live_q) begin
      if (cur_valid && !match_found_q && rd_key_q == key_q) begin
        match_found_q <= 1'b1;
      end
      if (!cur_valid && !free_found_q) begin
        free_found_q <= 1'b1;
      end
      if (cur_valid && rd_place_q < PlaceRend && better) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_live_q) begin
      if (cur_valid && !match_found_q && rd_key_q == key_q) begin
        match_idx_q   <= cur_idx_q;
        match_place_q <= rd_place_q;
      end
      if (!cur_valid && !free_found_q) begin
        free_idx_q <= cur_idx_q;
      end
      if (cur_valid && rd_place_q < PlaceRend && better) begin
        best_idx_q   <= cur_idx_q;
        best_place_q <= rd_place_q;
        best_age_q   <= cur_age;
      end
    end
  end

  // side reads, taken in the lookup state (indices are settled by then)
  always_ff @(posedge clk_i) begin
    m_orig_q <= orig_mem[match_idx_q];
    m_dup_q  <= dup_mem[match_idx_q];
    b_orig_q <= orig_mem[best_idx_q];
    b_key_q  <= key_mem[best_idx_q];
  end

  // decision
  logic             cls_ok;
  logic [LimW-1:0]  cnt_cls, cnt_mp;
  logic [DupW-1:0]  dup_inc;
  assign cls_ok  = (cls_q < ClsW'(NumCls)) && (cls_q != ClsDirty);
  assign cnt_cls = (cls_q < ClsW'(NumCls)) ? cnt_q[cls_q] : '0;
  assign cnt_mp  = (match_place_q < ClsW'(NumCls)) ? cnt_q[match_place_q] : '0;
  assign dup_inc = (m_dup_q == '1) ? m_dup_q : m_dup_q + 1'b1;

  logic             reply_d;
  logic [OutcW-1:0] outc_d;
  logic [KeyW-1:0]  rkey_d;
  logic [ClsW-1:0]  rcls_d;
  logic [LimW-1:0]  depth_d;
  logic [DupW-1:0]  rdup_d;

  logic               wr_en, inc_stamp, inc_drop, cnt_inc, cnt_dec, inv_en;
  logic [IdxW-1:0]    wr_idx;
  logic [ClsW-1:0]    wr_place, inc_cls, dec_cls;
  logic               wr_key, wr_orig, wr_stamp, wr_dup;
  logic [DupW-1:0]    wr_dup_val;

  always_comb begin
    reply_d = 1'b0; outc_d = OC_COUNT; rkey_d = '0; rcls_d = '0;
    depth_d = '0; rdup_d = '0;
    wr_en = 1'b0; wr_idx = match_idx_q; wr_place = cls_q;
    wr_key = 1'b0; wr_orig = 1'b0; wr_stamp = 1'b0; wr_dup = 1'b0;
    wr_dup_val = dup_inc;
    inc_stamp = 1'b0; inc_drop = 1'b0; cnt_inc = 1'b0; cnt_dec = 1'b0;
    inc_cls = cls_q; dec_cls = match_place_q; inv_en = 1'b0;
    case (op_e'(op_q))
      OP_ADD: begin
        if (match_found_q) begin
          if (cls_ok && match_place_q < PlaceRend && cls_q < match_place_q &&
              cnt_cls < request_limit_i) begin
            outc_d = OC_PROMOTED;
            wr_en = 1'b1; wr_orig = 1'b1; wr_stamp = 1'b1; wr_dup = 1'b1;
            inc_stamp = 1'b1; cnt_inc = 1'b1; cnt_dec = 1'b1;
          end else if (match_place_q == PlaceRend || match_place_q <= 3'd2) begin
            outc_d = OC_DUP;
            wr_dup = 1'b1;
          end else begin
            reply_d = 1'b1; outc_d = OC_MATCHBG;
          end
        end else if (free_found_q && cls_ok && cnt_cls < request_limit_i) begin
          outc_d = OC_QUEUED;
          wr_en = 1'b1; wr_idx = free_idx_q; wr_key = 1'b1; wr_orig = 1'b1;
          wr_stamp = 1'b1; wr_dup = 1'b1; wr_dup_val = '0;
          inc_stamp = 1'b1; cnt_inc = 1'b1;
        end else if (free_found_q && cnt_q[ClsDirty] < bg_limit_i) begin
          reply_d = 1'b1; outc_d = OC_DIRTY;
          wr_en = 1'b1; wr_idx = free_idx_q; wr_place = ClsDirty;
          wr_key = 1'b1; wr_orig = 1'b1; wr_stamp = 1'b1; wr_dup = 1'b1;
          wr_dup_val = '0; inc_stamp = 1'b1; cnt_inc = 1'b1; inc_cls = ClsDirty;
        end else begin
          reply_d = 1'b1; outc_d = OC_DROPPED; inc_drop = 1'b1;
        end
      end
      OP_FETCH: begin
        if (best_found_q) begin
          outc_d = OC_FETCHED; rkey_d = b_key_q; rcls_d = b_orig_q;
          wr_en = 1'b1; wr_idx = best_idx_q; wr_place = PlaceRend;
          cnt_dec = 1'b1; dec_cls = best_place_q;
        end else begin
          outc_d = OC_EMPTY;
        end
      end
      OP_COMPLETE: begin
        if (match_found_q && match_place_q == PlaceRend) begin
          outc_d = OC_REMOVED; rcls_d = m_orig_q; rdup_d = m_dup_q;
          inv_en = 1'b1;
        end else begin
          outc_d = OC_MISSING;
        end
      end
      OP_COUNT: begin
        outc_d  = OC_COUNT;
        depth_d = cnt_cls;
      end
      default: begin
        outc_d = OC_COUNT;
      end
    endcase
  end

  logic [IdxW-1:0] dup_idx;
  assign dup_idx = (op_q == OP_ADD && !match_found_q) ? free_idx_q : match_idx_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      if (wr_en) begin
        place_mem[wr_idx] <= wr_place;
      end
      if (wr_key) begin
        key_mem[wr_idx] <= key_q;
      end
      if (wr_orig) begin
        orig_mem[wr_idx] <= wr_place;
      end
      if (wr_stamp) begin
        stamp_mem[wr_idx] <= stamp_ctr_q;
      end
      if (wr_dup) begin
        dup_mem[dup_idx] <= wr_dup_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      stamp_ctr_q <= '0;
      drops_q     <= '0;
      for (int c = 0; c < NumCls; c++) begin
        cnt_q[c] <= '0;
      end
    end else if (ctrl_i.commit) begin
      if (wr_key) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (inv_en) begin
        valid_q[match_idx_q] <= 1'b0;
      end
      if (inc_stamp) begin
        stamp_ctr_q <= stamp_ctr_q + 1'b1;
      end
      if (inc_drop) begin
        drops_q <= drops_q + 1'b1;
      end
      for (int c = 0; c < NumCls; c++) begin
        if (cnt_inc && inc_cls == ClsW'(c) && !(cnt_dec && dec_cls == ClsW'(c))) begin
          cnt_q[c] <= cnt_q[c] + 1'b1;
        end else if (cnt_dec && dec_cls == ClsW'(c) &&
                     !(cnt_inc && inc_cls == ClsW'(c))) begin
          cnt_q[c] <= cnt_q[c] - 1'b1;
        end
      end
    end
  end

  logic             reply_q;
  logic [OutcW-1:0] outc_q;
  logic [KeyW-1:0]  rkey_q;
  logic [ClsW-1:0]  rcls_q;
  logic [LimW-1:0]  depth_q;
  logic [DupW-1:0]  rdup_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      reply_q <= reply_d; outc_q <= outc_d; rkey_q <= rkey_d;
      rcls_q <= rcls_d; depth_q <= depth_d; rdup_q <= rdup_d;
    end
  end

  assign reply_o           = done_i ? reply_q : 1'b0;
  assign outcome_o         = done_i ? outc_q  : '0;
  assign result_key_o      = done_i ? rkey_q  : '0;
  assign result_class_o    = done_i ? rcls_q  : '0;
  assign class_depth_o     = done_i ? depth_q : '0;
  assign duplicate_count_o = done_i ? rdup_q  : '0;
  assign drop_total_o      = drops_q;

`ifndef NO_ASSERTIONS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_live_q |-> $past(rd_live_q)) else $error("scan beat without address");
  a_drop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(ctrl_i.commit) |-> $stable(drops_q)) else $error("drops moved");
  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(ctrl_i.commit) |-> $stable(stamp_ctr_q)) else $error("stamp moved");
`endif

endmodule

// ----- design/tile_request_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// tile_request_priority_scheduler
// Strict-priority tile request table with coalescing of repeated tiles.
// ----------------------------------------------------------------------------
// usage:
//   command channel: drive operation_i, tile_key_i, request_class_i with
//   start high; the beat is taken when busy is low. inputs are captured.
//   result: strobe_o is high for one cycle with all result ports; the
//   receiver cannot hold it off. drop_total_o is always live.
//   configuration: cfg_valid_i/cfg_ready_o with cfg_index_i, cfg_data_i;
//   cfg_ready_o is always high; write only while idle.
// command flow:
//   every command sweeps the slot table memory one slot per cycle, then
//   passes the wait, lookup and decide states before the strobe; the next
//   command is taken the cycle after the strobe.
// reset:
//   table empty, class depths and drop count zero, limits at 32; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module tile_request_priority_scheduler import trps_pkg::*; #(
  parameter int unsigned Slots = SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OpW-1:0]      operation_i,
  input  logic [KeyW-1:0]     tile_key_i,
  input  logic [ClsW-1:0]     request_class_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [LimW-1:0]     cfg_data_i,
  output logic                strobe_o,
  output logic                reply_o,
  output logic [OutcW-1:0]    outcome_o,
  output logic [KeyW-1:0]     result_key_o,
  output logic [ClsW-1:0]     result_class_o,
  output logic [LimW-1:0]     class_depth_o,
  output logic [DupW-1:0]     duplicate_count_o,
  output logic [DropW-1:0]    drop_total_o
);

  logic [LimW-1:0] req_lim_q, dirty_lim_q;
  ctrl_t ctrl;
  stat_t stat;
  logic  done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_lim_q   <= RequestLimitReset;
      dirty_lim_q <= DirtyLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRequestLimit: req_lim_q   <= cfg_data_i;
        RegDirtyLimit:   dirty_lim_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  trps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .done_o (done)
  );

  trps_dp #(.Slots(Slots)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .done_i            (done),
    .operation_i       (operation_i),
    .tile_key_i        (tile_key_i),
    .request_class_i   (request_class_i),
    .request_limit_i   (req_lim_q),
    .bg_limit_i        (dirty_lim_q),
    .reply_o           (reply_o),
    .outcome_o         (outcome_o),
    .result_key_o      (result_key_o),
    .result_class_o    (result_class_o),
    .class_depth_o     (class_depth_o),
    .duplicate_count_o (duplicate_count_o),
    .drop_total_o      (drop_total_o)
  );

  assign strobe_o = done;

`ifndef NO_ASSERTIONS
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy) else $error("strobe while idle");
  a_no_double_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o) else $error("strobe repeated");
`endif

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tile request priority scheduler: a directed
// table of commands followed by random add/fetch/complete/count traffic over
// a small key pool, with limits reprogrammed between phases. Each strobe is
// checked against an in-bench model of the slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import trps_pkg::*;

  localparam int unsigned NSlots = 64;
  localparam int unsigned Drain  = NSlots + 20;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key;
    logic [ClsW-1:0] cls;
  } cmd_t;

  typedef struct packed {
    logic             reply;
    logic [OutcW-1:0] outc;
    logic [KeyW-1:0]  rkey;
    logic [ClsW-1:0]  rcls;
    logic [LimW-1:0]  depth;
    logic [DupW-1:0]  dupes;
    logic [DropW-1:0] drops;
  } res_t;

  typedef struct packed {
    logic  use_exp;
    cmd_t  cmd;
    res_t  exp;
  } row_t;

  logic             clk_i, rst_ni, start, busy;
  logic [OpW-1:0]   operation_i;
  logic [KeyW-1:0]  tile_key_i;
  logic [ClsW-1:0]  request_class_i;
  logic             cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [LimW-1:0]  cfg_data_i;
  logic             strobe_o, reply_o;
  logic [OutcW-1:0] outcome_o;
  logic [KeyW-1:0]  result_key_o;
  logic [ClsW-1:0]  result_class_o;
  logic [LimW-1:0]  class_depth_o;
  logic [DupW-1:0]  duplicate_count_o;
  logic [DropW-1:0] drop_total_o;

  tile_request_priority_scheduler #(.Slots(NSlots)) DUT (.*);

  // scheduler model state
  logic             m_valid [NSlots];
  logic [KeyW-1:0]  m_key   [NSlots];
  logic [2:0]       m_place [NSlots];
  logic [2:0]       m_origin[NSlots];
  logic [31:0]      m_stamp [NSlots];
  logic [7:0]       m_dupes [NSlots];
  logic [6:0]       m_depth [NumCls];
  logic [31:0]      m_clock, m_drops;
  logic [6:0]       req_limit, bg_limit;

  res_t  expected_q[$];
  res_t  typed_q[$];
  logic  typed_use_q[$];
  int    errors;

  task automatic report(input string what, input logic [127:0] got,
                        input logic [127:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int find_tile(input logic [KeyW-1:0] k);
    for (int i = 0; i < NSlots; i++) if (m_valid[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic res_t schedule(input cmd_t c);
    res_t r;
    int m, f, best;
    logic [2:0] tgt, bp;
    logic [31:0] ba, age;
    r = '0;
    case (op_e'(c.op))
      OP_ADD: begin
        m = find_tile(c.key);
        if (m >= 0) begin
          if (c.cls < NumCls && c.cls != ClsDirty && m_place[m] < PlaceRend &&
              c.cls < m_place[m] && m_depth[c.cls] < req_limit) begin
            m_depth[m_place[m]]--;
            m_depth[c.cls]++;
            m_place[m] = c.cls;
            m_origin[m] = c.cls;
            m_stamp[m] = m_clock++;
            if (m_dupes[m] != 8'hff) m_dupes[m]++;
            r.outc = OC_PROMOTED;
          end else if (m_place[m] == PlaceRend || m_place[m] <= 2) begin
            if (m_dupes[m] != 8'hff) m_dupes[m]++;
            r.outc = OC_DUP;
          end else begin
            r.reply = 1'b1;
            r.outc = OC_MATCHBG;
          end
        end else begin
          f = -1;
          for (int i = NSlots - 1; i >= 0; i--) if (!m_valid[i]) f = i;
          if (f >= 0 && c.cls < NumCls && c.cls != ClsDirty && m_depth[c.cls] < req_limit) begin
            tgt = c.cls;
            r.outc = OC_QUEUED;
          end else if (f >= 0 && m_depth[ClsDirty] < bg_limit) begin
            tgt = ClsDirty;
            r.reply = 1'b1;
            r.outc = OC_DIRTY;
          end else begin
            m_drops++;
            r.reply = 1'b1;
            r.outc = OC_DROPPED;
            f = -1;
          end
          if (f >= 0) begin
            m_valid[f] = 1'b1;
            m_key[f] = c.key;
            m_place[f] = tgt;
            m_origin[f] = tgt;
            m_stamp[f] = m_clock++;
            m_dupes[f] = '0;
            m_depth[tgt]++;
          end
        end
      end
      OP_FETCH: begin
        best = -1;
        bp = '0;
        ba = '0;
        for (int i = 0; i < NSlots; i++) begin
          if (m_valid[i] && m_place[i] < PlaceRend) begin
            age = m_clock - m_stamp[i];
            if (best < 0 || m_place[i] < bp || (m_place[i] == bp && age > ba)) begin
              best = i;
              bp = m_place[i];
              ba = age;
            end
          end
        end
        if (best < 0) r.outc = OC_EMPTY;
        else begin
          m_depth[bp]--;
          m_place[best] = PlaceRend;
          r.outc = OC_FETCHED;
          r.rkey = m_key[best];
          r.rcls = m_origin[best];
        end
      end
      OP_COMPLETE: begin
        m = find_tile(c.key);
        if (m < 0 || m_place[m] != PlaceRend) r.outc = OC_MISSING;
        else begin
          m_valid[m] = 1'b0;
          r.outc = OC_REMOVED;
          r.rcls = m_origin[m];
          r.dupes = m_dupes[m];
        end
      end
      default: begin
        r.outc = OC_COUNT;
        if (c.cls < NumCls) r.depth = m_depth[c.cls];
      end
    endcase
    r.drops = m_drops;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (expected_q.size() == 0) report("unexpected beat", 128'(outcome_o), 128'(0));
      else begin
        res_t e;
        logic u;
        e = expected_q.pop_front();
        u = typed_use_q.pop_front();
        if (u) begin
          res_t t;
          t = typed_q.pop_front();
          if (t != e) report("table row vs model", 128'(t), 128'(e));
        end
        if (reply_o !== e.reply) report("reply", 128'(reply_o), 128'(e.reply));
        if (outcome_o !== e.outc) report("outcome", 128'(outcome_o), 128'(e.outc));
        if (result_key_o !== e.rkey)
          report("result_key", 128'(result_key_o), 128'(e.rkey));
        if (result_class_o !== e.rcls)
          report("result_class", 128'(result_class_o), 128'(e.rcls));
        if (class_depth_o !== e.depth)
          report("class_depth", 128'(class_depth_o), 128'(e.depth));
        if (duplicate_count_o !== e.dupes)
          report("duplicate_count", 128'(duplicate_count_o), 128'(e.dupes));
        if (drop_total_o !== e.drops)
          report("drop_total", 128'(drop_total_o), 128'(e.drops));
      end
    end
  end

  int burst;

  task automatic send(input cmd_t c, input logic use_exp, input res_t t);
    if (burst == 0) begin
      burst = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    burst--;
    start <= 1'b1;
    operation_i <= c.op;
    tile_key_i <= c.key;
    request_class_i <= c.cls;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(schedule(c));
    typed_use_q.push_back(use_exp);
    if (use_exp) typed_q.push_back(t);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle;
    int n;
    n = 0;
    while (expected_q.size() != 0 && n < 100_000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CfgIdxW-1:0] idx, input logic [LimW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegRequestLimit) req_limit = v;
    else bg_limit = v;
    @(posedge clk_i);
  endtask

  function automatic cmd_t mk(input op_e o, input logic [KeyW-1:0] k, input logic [2:0] c);
    cmd_t r;
    r.op = o;
    r.key = k;
    r.cls = c;
    return r;
  endfunction

  function automatic res_t want(input logic rp, input outcome_e o, input logic [KeyW-1:0] k,
                                input logic [2:0] c, input logic [6:0] d,
                                input logic [7:0] du, input logic [31:0] dr);
    res_t r;
    r = '{rp, o, k, c, d, du, dr};
    return r;
  endfunction

  row_t rows[$];
  logic [KeyW-1:0] pool[16];

  initial begin
    cmd_t c;
    logic [KeyW-1:0] kmax;
    kmax = '1;
    errors = 0;
    burst = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = '0;
    tile_key_i = '0;
    request_class_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    for (int i = 0; i < NSlots; i++) m_valid[i] = 1'b0;
    for (int i = 0; i < NumCls; i++) m_depth[i] = '0;
    m_clock = '0;
    m_drops = '0;
    req_limit = RequestLimitReset;
    bg_limit = DirtyLimitReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    rows.push_back('{1, mk(OP_FETCH, 0, 0), want(0, OC_EMPTY, 0, 0, 0, 0, 0)});
    rows.push_back('{1, mk(OP_COMPLETE, kmax, 0), want(0, OC_MISSING, 0, 0, 0, 0, 0)});
    rows.push_back('{1, mk(OP_COUNT, 0, 7), want(0, OC_COUNT, 0, 0, 0, 0, 0)});
    rows.push_back('{1, mk(OP_ADD, kmax, 2), want(0, OC_QUEUED, 0, 0, 0, 0, 0)});
    rows.push_back('{1, mk(OP_ADD, kmax, 0), want(0, OC_PROMOTED, 0, 0, 0, 0, 0)});
    rows.push_back('{0, mk(OP_ADD, 0, 4), '0});
    rows.push_back('{0, mk(OP_ADD, 0, 1), '0});
    rows.push_back('{0, mk(OP_ADD, 5, 3), '0});
    rows.push_back('{0, mk(OP_ADD, 5, 0), '0});
    rows.push_back('{0, mk(OP_ADD, 6, 7), '0});
    rows.push_back('{0, mk(OP_ADD, 6, 2), '0});
    rows.push_back('{0, mk(OP_COUNT, 0, 3), '0});
    rows.push_back('{0, mk(OP_COUNT, 0, 4), '0});
    rows.push_back('{0, mk(OP_FETCH, 0, 0), '0});
    rows.push_back('{0, mk(OP_ADD, kmax, 1), '0});
    rows.push_back('{0, mk(OP_COMPLETE, 5, 0), '0});
    rows.push_back('{0, mk(OP_COMPLETE, kmax, 0), '0});
    rows.push_back('{0, mk(OP_FETCH, 0, 0), '0});
    rows.push_back('{0, mk(OP_FETCH, 0, 0), '0});
    rows.push_back('{0, mk(OP_FETCH, 0, 0), '0});
    rows.push_back('{0, mk(OP_FETCH, 0, 0), '0});
    rows.push_back('{0, mk(OP_COUNT, 0, 0), '0});
    foreach (rows[i]) send(rows[i].cmd, rows[i].use_exp, rows[i].exp);
    settle();

    // random phases with limits swept across extremes
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_limit(RegRequestLimit, 1); write_limit(RegDirtyLimit, 0); end
        1: begin write_limit(RegRequestLimit, 64); write_limit(RegDirtyLimit, 64); end
        2: begin write_limit(RegRequestLimit, 2); write_limit(RegDirtyLimit, 3); end
        3: begin write_limit(RegRequestLimit, 127); write_limit(RegDirtyLimit, 127); end
        default: begin
          write_limit(RegRequestLimit, 7'($urandom_range(1, 64)));
          write_limit(RegDirtyLimit, 7'($urandom_range(0, 64)));
        end
      endcase
      for (int i = 0; i < 16; i++) begin
        pool[i][KeyW-1:32] = (KeyW-32)'($urandom());
        pool[i][31:0] = $urandom();
      end
      for (int n = 0; n < 100; n++) begin
        int sel;
        sel = $urandom_range(0, 99);
        c.key = pool[$urandom_range(0, 15)];
        c.cls = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                3'($urandom_range(0, 4));
        if (sel < 45) c.op = OP_ADD;
        else if (sel < 70) c.op = OP_FETCH;
        else if (sel < 92) c.op = OP_COMPLETE;
        else c.op = OP_COUNT;
        if ($urandom_range(0, 15) == 0) begin
          c.key[KeyW-1:32] = (KeyW-32)'($urandom());
          c.key[31:0] = $urandom();
        end
        send(c, 1'b0, '0);
      end
      settle();
    end

    if (errors == 0 && expected_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/trps_pkg.sv
design/trps_ctrl.sv
design/trps_dp.sv
design/tile_request_priority_scheduler.sv
dv/tb.sv
